[rtl/lrfs_pkg.sv]
// Shared types, codes and reset constants for the link retry and fallback supervisor.
package lrfs_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgIndexW = 3;

    typedef logic [TimeW-1:0] time_ms_t;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_START        = 3'd1,
        OP_STA_START    = 3'd2,
        OP_DISCONNECTED = 3'd3,
        OP_GOT_IP       = 3'd4,
        OP_LOST_IP      = 3'd5,
        OP_AP_STARTED   = 3'd6,
        OP_AP_STOPPED   = 3'd7
    } op_t;

    typedef enum logic [CfgIndexW-1:0] {
        REG_HAS_CREDENTIALS   = 3'd0,
        REG_NORMAL_RETRY_MS   = 3'd1,
        REG_FAST_RETRY_MS     = 3'd2,
        REG_FAST_WINDOW_MS    = 3'd3,
        REG_FALLBACK_DELAY_MS = 3'd4
    } cfg_index_t;

    localparam time_ms_t NormalRetryReset   = 32'd5000;
    localparam time_ms_t FastRetryReset     = 32'd1000;
    localparam time_ms_t FastWindowReset    = 32'd15000;
    localparam time_ms_t FallbackDelayReset = 32'd120000;

    typedef struct packed {
        logic     has_credentials;
        time_ms_t normal_retry_ms;
        time_ms_t fast_retry_ms;
        time_ms_t fast_window_ms;
        time_ms_t fallback_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic     connected;
        logic     fallback_on;
        time_ms_t last_disconnect_time;
        time_ms_t streak_start_time;
        time_ms_t last_retry_time;
    } sup_state_t;

    typedef struct packed {
        logic connect_request;
        logic enable_fallback;
        logic disable_fallback;
        logic link_up;
        logic fallback_active;
    } result_t;

endpackage

[rtl/lrfs_step.sv]
// Next-state and result logic for one supervisor event or tick.
module lrfs_step (
    input  lrfs_pkg::cfg_t       cfg,
    input  lrfs_pkg::sup_state_t state,
    input  lrfs_pkg::op_t        op,
    input  lrfs_pkg::time_ms_t   now,
    output lrfs_pkg::sup_state_t state_next,
    output lrfs_pkg::result_t    result
);
    import lrfs_pkg::*;

    time_ms_t streak_eff;
    time_ms_t retry_ref;
    time_ms_t interval;
    logic     delay_reached;
    logic     retry_due;

    // A streak start of zero means no streak is open.
    assign streak_eff = (state.streak_start_time == '0) ? now : state.streak_start_time;
    assign delay_reached = (time_ms_t'(now - streak_eff)) >= cfg.fallback_delay_ms;
    assign interval = ((time_ms_t'(now - state.last_disconnect_time)) < cfg.fast_window_ms)
                      ? cfg.fast_retry_ms : cfg.normal_retry_ms;
    // The retry reference is the later of the two stamps, compared without wrap.
    assign retry_ref = (state.last_retry_time < state.last_disconnect_time)
                       ? state.last_disconnect_time : state.last_retry_time;
    assign retry_due = (time_ms_t'(now - retry_ref)) >= interval;

    always_comb
    begin
        logic req;
        logic en;
        logic dis;
        state_next = state;
        req = 1'b0;
        en  = 1'b0;
        dis = 1'b0;
        unique case (op)
            OP_TICK:
            begin
                priority if (!cfg.has_credentials)
                begin
                    if (!state.fallback_on)
                    begin
                        state_next.fallback_on = 1'b1;
                        en = 1'b1;
                    end
                end
                else if (state.connected)
                begin
                    state_next.streak_start_time = '0;
                    if (state.fallback_on)
                    begin
                        state_next.fallback_on = 1'b0;
                        dis = 1'b1;
                    end
                end
                else
                begin
                    state_next.streak_start_time = streak_eff;
                    if (!state.fallback_on && delay_reached)
                    begin
                        state_next.fallback_on = 1'b1;
                        en = 1'b1;
                    end
                    if (retry_due)
                    begin
                        state_next.last_retry_time = now;
                        req = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                if (!cfg.has_credentials)
                begin
                    state_next.fallback_on = 1'b1;
                    en = 1'b1;
                end
                else
                begin
                    state_next.last_disconnect_time = now;
                    state_next.streak_start_time    = now;
                end
            end
            OP_STA_START:
            begin
                req = 1'b1;
            end
            OP_DISCONNECTED:
            begin
                state_next.connected            = 1'b0;
                state_next.last_disconnect_time = now;
                state_next.streak_start_time    = streak_eff;
            end
            OP_GOT_IP:
            begin
                state_next.connected         = 1'b1;
                state_next.streak_start_time = '0;
            end
            OP_LOST_IP:
            begin
                state_next.connected         = 1'b0;
                state_next.streak_start_time = streak_eff;
            end
            OP_AP_STARTED:
            begin
                state_next.fallback_on = 1'b1;
            end
            OP_AP_STOPPED:
            begin
                state_next.fallback_on = 1'b0;
            end
            default:
            begin
                state_next = state;
            end
        endcase
        result.connect_request  = req;
        result.enable_fallback  = en;
        result.disable_fallback = dis;
        result.link_up          = state_next.connected;
        result.fallback_active  = state_next.fallback_on;
    end

endmodule

[rtl/link_retry_fallback_supervisor_core.sv]
// An accepted transaction is held in the input register, then in the result register.
// Throughput: one transaction per cycle unless the output stalls; the supervisor state
// is read and rewritten in the cycle that moves a transaction into the result register.
// Reset: rst_n clears both stage valids, the link and fallback flags and all time stamps,
// and loads the configuration registers with their documented defaults.
module link_retry_fallback_supervisor_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [lrfs_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [lrfs_pkg::TimeW-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 operation,
    input  logic [lrfs_pkg::TimeW-1:0] now_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       connect_request,
    output logic                       enable_fallback,
    output logic                       disable_fallback,
    output logic                       link_up,
    output logic                       fallback_active
);
    import lrfs_pkg::*;

    cfg_t       cfg_reg;
    sup_state_t state_reg;
    sup_state_t state_next;
    result_t    step_result;
    result_t    result_reg;
    logic       in_valid_reg;
    op_t        op_reg;
    time_ms_t   now_reg;
    logic       out_valid_reg;
    logic       advance;
    logic       in_take;

    // The result register loads a held transaction when empty or when its own is taken.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    lrfs_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .op         (op_reg),
        .now        (now_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.has_credentials   <= 1'b0;
            cfg_reg.normal_retry_ms   <= NormalRetryReset;
            cfg_reg.fast_retry_ms     <= FastRetryReset;
            cfg_reg.fast_window_ms    <= FastWindowReset;
            cfg_reg.fallback_delay_ms <= FallbackDelayReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HAS_CREDENTIALS:   cfg_reg.has_credentials   <= cfg_data[0];
                REG_NORMAL_RETRY_MS:   cfg_reg.normal_retry_ms   <= cfg_data;
                REG_FAST_RETRY_MS:     cfg_reg.fast_retry_ms     <= cfg_data;
                REG_FAST_WINDOW_MS:    cfg_reg.fast_window_ms    <= cfg_data;
                REG_FALLBACK_DELAY_MS: cfg_reg.fallback_delay_ms <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= op_t'(operation);
            now_reg <= now_ms;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign connect_request  = result_reg.connect_request;
    assign enable_fallback  = result_reg.enable_fallback;
    assign disable_fallback = result_reg.disable_fallback;
    assign link_up          = result_reg.link_up;
    assign fallback_active  = result_reg.fallback_active;

endmodule

[dv/link_retry_fallback_supervisor_core_tb.sv]
// Self-checking testbench for the link retry and fallback supervisor core.
module link_retry_fallback_supervisor_core_tb;

    import lrfs_pkg::*;

    localparam int unsigned LongHoldCycles = 48;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CfgIndexW-1:0] cfg_index;
    time_ms_t             cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           operation;
    time_ms_t             now_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic                 connect_request;
    logic                 enable_fallback;
    logic                 disable_fallback;
    logic                 link_up;
    logic                 fallback_active;

    // Mirror of the register file and of the supervisor state.
    cfg_t        regs_mirror;
    sup_state_t  link_state;
    result_t     pending_outcomes[$];
    result_t     oldest;
    int unsigned mismatch_count = 0;

    time_ms_t    wall_ms = '0;
    int unsigned step_ceiling = 2000;
    logic        long_hold_pending = 1'b0;
    logic        long_hold_active = 1'b0;

    link_retry_fallback_supervisor_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .connect_request  (connect_request),
        .enable_fallback  (enable_fallback),
        .disable_fallback (disable_fallback),
        .link_up          (link_up),
        .fallback_active  (fallback_active)
    );

    always #4 clk = ~clk;

    function automatic void open_streak(time_ms_t t);
        if (link_state.streak_start_time == '0)
        begin
            link_state.streak_start_time = t;
        end
    endfunction

    // Advances the mirrored supervisor by one event and returns its outcome.
    function automatic result_t supervise_event(op_t op, time_ms_t t);
        result_t  r;
        time_ms_t elapsed;
        time_ms_t interval;
        time_ms_t retry_base;
        r = '0;
        case (op)
            OP_TICK:
            begin
                if (!regs_mirror.has_credentials)
                begin
                    if (!link_state.fallback_on)
                    begin
                        link_state.fallback_on = 1'b1;
                        r.enable_fallback = 1'b1;
                    end
                end
                else if (link_state.connected)
                begin
                    link_state.streak_start_time = '0;
                    if (link_state.fallback_on)
                    begin
                        link_state.fallback_on = 1'b0;
                        r.disable_fallback = 1'b1;
                    end
                end
                else
                begin
                    open_streak(t);
                    elapsed = t - link_state.streak_start_time;
                    if (!link_state.fallback_on && elapsed >= regs_mirror.fallback_delay_ms)
                    begin
                        link_state.fallback_on = 1'b1;
                        r.enable_fallback = 1'b1;
                    end
                    elapsed = t - link_state.last_disconnect_time;
                    interval = (elapsed < regs_mirror.fast_window_ms) ?
                               regs_mirror.fast_retry_ms : regs_mirror.normal_retry_ms;
                    // The retry base is the later stamp compared without wrap.
                    retry_base = (link_state.last_retry_time < link_state.last_disconnect_time) ?
                                 link_state.last_disconnect_time : link_state.last_retry_time;
                    elapsed = t - retry_base;
                    if (elapsed >= interval)
                    begin
                        link_state.last_retry_time = t;
                        r.connect_request = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                if (!regs_mirror.has_credentials)
                begin
                    link_state.fallback_on = 1'b1;
                    r.enable_fallback = 1'b1;
                end
                else
                begin
                    link_state.last_disconnect_time = t;
                    link_state.streak_start_time = t;
                end
            end
            OP_STA_START:
            begin
                r.connect_request = 1'b1;
            end
            OP_DISCONNECTED:
            begin
                link_state.connected = 1'b0;
                link_state.last_disconnect_time = t;
                open_streak(t);
            end
            OP_GOT_IP:
            begin
                link_state.connected = 1'b1;
                link_state.streak_start_time = '0;
            end
            OP_LOST_IP:
            begin
                link_state.connected = 1'b0;
                open_streak(t);
            end
            OP_AP_STARTED:
            begin
                link_state.fallback_on = 1'b1;
            end
            default:
            begin
                link_state.fallback_on = 1'b0;
            end
        endcase
        r.link_up = link_state.connected;
        r.fallback_active = link_state.fallback_on;
        return r;
    endfunction

    function automatic void check_field(string field, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result transaction arrived with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                oldest = pending_outcomes.pop_front();
                check_field("connect_request", oldest.connect_request, connect_request);
                check_field("enable_fallback", oldest.enable_fallback, enable_fallback);
                check_field("disable_fallback", oldest.disable_fallback, disable_fallback);
                check_field("link_up", oldest.link_up, link_up);
                check_field("fallback_active", oldest.fallback_active, fallback_active);
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off on request.
    initial
    begin : out_stall_pattern
        int unsigned mode;
        int unsigned run;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                long_hold_active = 1'b1;
                out_stall <= 1'b1;
                repeat (LongHoldCycles) @(posedge clk);
                long_hold_active = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                run = $urandom_range(8, 64);
                repeat (run)
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 9) < 7);
                        default: out_stall <= ~out_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    task automatic send_event(op_t op, time_ms_t t);
        operation <= op;
        now_ms <= t;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_outcomes.push_back(supervise_event(op, t));
    endtask

    task automatic pause_sender(int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Waits until every outstanding transaction has returned and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(logic [CfgIndexW-1:0] idx, time_ms_t value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_HAS_CREDENTIALS:   regs_mirror.has_credentials = value[0];
            REG_NORMAL_RETRY_MS:   regs_mirror.normal_retry_ms = value;
            REG_FAST_RETRY_MS:     regs_mirror.fast_retry_ms = value;
            REG_FAST_WINDOW_MS:    regs_mirror.fast_window_ms = value;
            REG_FALLBACK_DELAY_MS: regs_mirror.fallback_delay_ms = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(logic cred, time_ms_t normal, time_ms_t fast,
                                  time_ms_t window, time_ms_t delay);
        time_ms_t cred_word;
        cred_word = $urandom();
        cred_word[0] = cred;
        drain();
        write_config(REG_HAS_CREDENTIALS, cred_word);
        write_config(REG_NORMAL_RETRY_MS, normal);
        write_config(REG_FAST_RETRY_MS, fast);
        write_config(REG_FAST_WINDOW_MS, window);
        write_config(REG_FALLBACK_DELAY_MS, delay);
    endtask

    function automatic op_t random_op();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return OP_TICK;
        else if (pick < 58) return OP_STA_START;
        else if (pick < 67) return OP_DISCONNECTED;
        else if (pick < 73) return OP_GOT_IP;
        else if (pick < 79) return OP_LOST_IP;
        else if (pick < 84) return OP_START;
        else if (pick < 92) return OP_AP_STARTED;
        else return OP_AP_STOPPED;
    endfunction

    // Mostly small forward steps, with jumps, repeats and the odd zero stamp.
    function automatic time_ms_t next_time();
        int unsigned pick;
        pick = $urandom_range(0, 39);
        if (pick < 2)
            wall_ms = $urandom();
        else if (pick == 2)
            wall_ms = '0;
        else if (pick < 5)
            wall_ms = wall_ms;
        else if (pick < 8)
            wall_ms = wall_ms + $urandom_range(0, 200000);
        else
            wall_ms = wall_ms + $urandom_range(0, step_ceiling);
        return wall_ms;
    endfunction

    task automatic run_random_traffic(int unsigned count);
        int unsigned burst;
        burst = $urandom_range(1, 24);
        repeat (count)
        begin
            send_event(random_op(), next_time());
            burst--;
            if (burst == 0)
            begin
                pause_sender($urandom_range(1, 8));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                        $urandom_range(1, 24);
            end
        end
    endtask

    // Runs right after reset, so the register defaults apply.
    task automatic test_without_credentials();
        send_event(OP_TICK, 32'd100);
        send_event(OP_TICK, 32'd200);
        send_event(OP_START, 32'd300);
        send_event(OP_STA_START, 32'd400);
        send_event(OP_AP_STOPPED, 32'd500);
        send_event(OP_GOT_IP, 32'd600);
        pause_sender(3);
        send_event(OP_TICK, 32'd700);
        send_event(OP_LOST_IP, 32'd800);
    endtask

    task automatic test_link_events();
        apply_settings(1'b1, NormalRetryReset, FastRetryReset, FastWindowReset,
                       FallbackDelayReset);
        send_event(OP_START, 32'd1000);
        send_event(OP_TICK, 32'd1500);
        send_event(OP_TICK, 32'd2000);
        send_event(OP_DISCONNECTED, 32'd0);
        send_event(OP_TICK, 32'hFFFF_FFFF);
        send_event(OP_AP_STARTED, 32'd10);
        send_event(OP_GOT_IP, 32'd20);
        send_event(OP_TICK, 32'd30);
        send_event(OP_AP_STOPPED, 32'd40);
        // A streak opened at time zero reads as no streak, so the next tick reopens it.
        send_event(OP_LOST_IP, 32'd0);
        send_event(OP_TICK, 32'd50);
        send_event(OP_DISCONNECTED, 32'hFFFF_FFF0);
        send_event(OP_TICK, 32'd5);
        send_event(OP_TICK, 32'd200000);
    endtask

    task automatic test_unmapped_registers();
        drain();
        for (int idx = int'(REG_FALLBACK_DELAY_MS) + 1; idx < (1 << CfgIndexW); idx++)
        begin
            write_config(idx[CfgIndexW-1:0], $urandom());
        end
        run_random_traffic(30);
    endtask

    task automatic test_output_backpressure();
        drain();
        long_hold_pending = 1'b1;
        while (!long_hold_active) @(posedge clk);
        repeat (16) send_event(random_op(), next_time());
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    apply_settings(1'b1, 32'd5000, 32'd1000, 32'd15000, 32'd120000);
                    step_ceiling = 20000;
                end
                1:
                begin
                    apply_settings(1'b1, 32'd300, 32'd40, 32'd900, 32'd2000);
                    step_ceiling = 400;
                    wall_ms = 32'hFFFF_F000;
                end
                2:
                begin
                    apply_settings(1'b1, '0, '0, '0, '0);
                    step_ceiling = 100;
                end
                3:
                begin
                    apply_settings(1'b1, '1, '1, '1, '1);
                    step_ceiling = 5000;
                end
                4:
                begin
                    apply_settings(1'b0, $urandom(), $urandom(), $urandom(), $urandom());
                    step_ceiling = 1000;
                end
                5:
                begin
                    apply_settings(1'b1, $urandom_range(0, 5000), $urandom_range(0, 1000),
                                   $urandom_range(0, 20000), $urandom_range(0, 60000));
                    step_ceiling = 3000;
                end
                default:
                begin
                    apply_settings(1'b1, $urandom(), $urandom(), $urandom(), $urandom());
                    step_ceiling = 1 << 20;
                end
            endcase
            run_random_traffic(240);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_TICK;
        now_ms = '0;
        regs_mirror = '{has_credentials: 1'b0, normal_retry_ms: NormalRetryReset,
                        fast_retry_ms: FastRetryReset, fast_window_ms: FastWindowReset,
                        fallback_delay_ms: FallbackDelayReset};
        link_state = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_without_credentials();
        test_link_events();
        test_unmapped_registers();
        test_output_backpressure();
        test_random_settings();

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
